/* design/assert_macros.svh */
// Assertion macros shared by the SHA-256 stream hash RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check on every rising edge while reset is low.
`define SHA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Check on every rising edge, reset included.
`define SHA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SHA_ASSERT(lbl, clk, rst, prop)
`define SHA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* design/sha_pkg.sv */
// Types, constants and round functions of the SHA-256 stream hash.
// No dependencies; used by sha_round_dp and sha256_stream_hash_top.
package sha_pkg;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_UPD
  } state_t;

  typedef enum logic [1:0] {
    WV_HOLD,
    WV_SHIFT,
    WV_ROUND
  } wv_op_t;

  typedef struct packed {
    wv_op_t     op;
    logic [5:0] rnd;
    logic       use_block;
  } dp_ctl_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* design/sha_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies; instantiated for the block words and the chaining words.
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sha_round_dp.sv */
// SHA-256 round datapath: working variables a..h and the 16-word schedule window.
// Depends on sha_pkg for the control struct, round constants and sigma functions.
module sha_round_dp (
  input  logic             clk,
  input  sha_pkg::dp_ctl_t ctl,
  input  logic [31:0]      shift_in,
  input  logic [31:0]      block_word,
  output logic [31:0]      wv_a
);

  logic [31:0] wv  [8];
  logic [31:0] win [16];
  logic [31:0] w;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // win[15] holds w[t-1], so w[t-2] sits at win[14] and w[t-16] at win[0].
  always_comb begin
    if (ctl.use_block) begin
      w = block_word;
    end else begin
      w = sha_pkg::small_sigma1(win[14]) + win[9] + sha_pkg::small_sigma0(win[1]) + win[0];
    end
    ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1  = wv[7] + sha_pkg::big_sigma1(wv[4]) + ch + sha_pkg::round_k(ctl.rnd) + w;
    t2  = sha_pkg::big_sigma0(wv[0]) + maj;
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      sha_pkg::WV_SHIFT: begin
        // Chaining words stream in word 0 first and end up in a..h.
        for (int i = 0; i < 7; i++) begin
          wv[i] <= wv[i+1];
        end
        wv[7] <= shift_in;
      end
      sha_pkg::WV_ROUND: begin
        wv[7] <= wv[6];
        wv[6] <= wv[5];
        wv[5] <= wv[4];
        wv[4] <= wv[3] + t1;
        wv[3] <= wv[2];
        wv[2] <= wv[1];
        wv[1] <= wv[0];
        wv[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i+1];
        end
        win[15] <= w;
      end
      default: begin
      end
    endcase
  end

  assign wv_a = wv[0];

endmodule

/* design/sha256_stream_hash_top.sv */
// Top level of the SHA-256 stream hash: byte packing, padding and block sequencer.
// Depends on sha_pkg, sha_ram, sha_round_dp and assert_macros.svh.
//
//  channel  | direction | handshake                  | payload
//  msg      | in        | msg_valid / msg_ready       | message_byte, byte_present,
//           |           |                             | end_of_message
//  digest   | out       | digest_valid / digest_ready | digest_high .. digest_low
//
// A data beat is accepted while msg_ready is high. Every 64th byte starts a
// compression: a load phase (chaining RAM read), 64 rounds and an update
// phase. An end beat adds 9 to 72 padding bytes, one per cycle outside the
// compressions, plus one or two compressions. After reset, S_INIT writes the
// initial hash into the chaining RAM before msg_ready rises. A held digest only
// stalls the final chaining update of the next message.
`include "assert_macros.svh"
module sha256_stream_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [7:0]  message_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [63:0] digest_high,
  output logic [63:0] digest_upper_mid,
  output logic [63:0] digest_lower_mid,
  output logic [63:0] digest_low
);

  sha_pkg::state_t  state, state_next;
  logic [3:0]       cnt, cnt_next;
  logic [5:0]       rnd, rnd_next;
  logic [5:0]       pos;
  logic [60:0]      count;
  logic [23:0]      acc;
  logic             pad_active, sent80, len_ok, fin;
  logic [255:0]     digest;

  logic             accept;
  logic             place_en;
  logic [7:0]       place_byte;
  logic [7:0]       len_byte;
  logic [63:0]      bit_len;
  logic [2:0]       len_idx;
  logic             block_full;
  logic             pad_final;
  logic             upd_stall;
  logic [31:0]      sum;

  logic             bw_en;
  logic [3:0]       bw_addr;
  logic [31:0]      bw_data;
  logic [3:0]       br_addr;
  logic [31:0]      br_data;
  logic             cw_en;
  logic [2:0]       cw_addr;
  logic [31:0]      cw_data;
  logic [2:0]       cr_addr;
  logic [31:0]      cr_data;
  logic [3:0]       cnt_m1;

  sha_pkg::dp_ctl_t dp_ctl;
  logic [31:0]      wv_a;

  sha_ram #(.WIDTH(32), .DEPTH(16)) u_block_ram (
    .clk   (clk),
    .we    (bw_en),
    .waddr (bw_addr),
    .wdata (bw_data),
    .raddr (br_addr),
    .rdata (br_data)
  );

  sha_ram #(.WIDTH(32), .DEPTH(8)) u_chain_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (cr_addr),
    .rdata (cr_data)
  );

  sha_round_dp u_dp (
    .clk        (clk),
    .ctl        (dp_ctl),
    .shift_in   (cr_data),
    .block_word (br_data),
    .wv_a       (wv_a)
  );

  assign msg_ready = (state == sha_pkg::S_IDLE);
  assign accept    = msg_valid && msg_ready;

  assign bit_len  = {count, 3'b000};
  assign len_idx  = 3'd7 - pos[2:0];
  assign len_byte = bit_len[{len_idx, 3'b000} +: 8];

  // Byte placer shared by data beats and the padding sequence.
  always_comb begin
    place_en   = 1'b0;
    place_byte = message_byte;
    if (state == sha_pkg::S_IDLE) begin
      place_en = accept && byte_present;
    end else if (state == sha_pkg::S_PAD) begin
      place_en = 1'b1;
      if (!sent80) begin
        place_byte = sha_pkg::PAD_BYTE;
      end else if (pos >= sha_pkg::LEN_START && len_ok) begin
        place_byte = len_byte;
      end else begin
        place_byte = 8'h00;
      end
    end
  end

  assign block_full = place_en && (pos == 6'd63);
  assign pad_final  = (state == sha_pkg::S_PAD) && sent80 && len_ok && (pos == 6'd63);
  assign bw_en      = place_en && (pos[1:0] == 2'd3);
  assign bw_addr    = pos[5:2];
  assign bw_data    = {acc, place_byte};
  assign upd_stall  = (cnt == 4'd0) && fin && digest_valid;
  assign sum        = cr_data + wv_a;
  assign cnt_m1     = cnt - 4'd1;

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    rnd_next         = rnd;
    br_addr          = rnd[3:0] + 4'd1;
    cr_addr          = cnt[2:0];
    cw_en            = 1'b0;
    cw_addr          = cnt_m1[2:0];
    cw_data          = sum;
    dp_ctl.op        = sha_pkg::WV_HOLD;
    dp_ctl.rnd       = rnd;
    dp_ctl.use_block = (rnd[5:4] == 2'b00);
    case (state)
      sha_pkg::S_INIT: begin
        cw_en   = 1'b1;
        cw_addr = cnt[2:0];
        cw_data = sha_pkg::init_h(cnt[2:0]);
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd7) begin
          cnt_next   = 4'd0;
          state_next = sha_pkg::S_IDLE;
        end
      end
      sha_pkg::S_IDLE: begin
        if (block_full) begin
          cnt_next   = 4'd0;
          state_next = sha_pkg::S_LOAD;
        end else if (accept && end_of_message) begin
          state_next = sha_pkg::S_PAD;
        end
      end
      sha_pkg::S_PAD: begin
        if (block_full) begin
          cnt_next   = 4'd0;
          state_next = sha_pkg::S_LOAD;
        end
      end
      sha_pkg::S_LOAD: begin
        br_addr  = 4'd0;
        cnt_next = cnt + 4'd1;
        if (cnt != 4'd0) begin
          dp_ctl.op = sha_pkg::WV_SHIFT;
        end
        if (cnt == 4'd8) begin
          cnt_next   = 4'd0;
          rnd_next   = 6'd0;
          state_next = sha_pkg::S_ROUND;
        end
      end
      sha_pkg::S_ROUND: begin
        dp_ctl.op = sha_pkg::WV_ROUND;
        rnd_next  = rnd + 6'd1;
        if (rnd == 6'd63) begin
          cnt_next   = 4'd0;
          state_next = sha_pkg::S_UPD;
        end
      end
      sha_pkg::S_UPD: begin
        if (!upd_stall) begin
          cnt_next = cnt + 4'd1;
          if (cnt != 4'd0) begin
            dp_ctl.op = sha_pkg::WV_SHIFT;
            cw_en     = 1'b1;
            // The last block of a message restores the initial hash.
            cw_data   = fin ? sha_pkg::init_h(cnt_m1[2:0]) : sum;
          end
          if (cnt == 4'd8) begin
            cnt_next = 4'd0;
            if (fin || !pad_active) begin
              state_next = sha_pkg::S_IDLE;
            end else begin
              state_next = sha_pkg::S_PAD;
            end
          end
        end
      end
      default: begin
        state_next = sha_pkg::S_INIT;
        cnt_next   = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::S_INIT;
      cnt   <= 4'd0;
      rnd   <= 6'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rnd   <= rnd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 6'd0;
      count        <= 61'd0;
      pad_active   <= 1'b0;
      sent80       <= 1'b0;
      len_ok       <= 1'b0;
      fin          <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      if (digest_valid && digest_ready) begin
        digest_valid <= 1'b0;
      end
      if (place_en) begin
        pos <= pos + 6'd1;
      end
      if (accept && byte_present) begin
        count <= count + 61'd1;
      end
      if (accept && end_of_message) begin
        pad_active <= 1'b1;
      end
      if (state == sha_pkg::S_PAD) begin
        if (!sent80) begin
          sent80 <= 1'b1;
          if (pos < sha_pkg::LEN_START) begin
            len_ok <= 1'b1;
          end
        end
        // Once the padding wraps into a fresh block the length may follow.
        if (block_full) begin
          len_ok <= 1'b1;
        end
        if (pad_final) begin
          fin <= 1'b1;
        end
      end
      if (state == sha_pkg::S_UPD && !upd_stall && cnt == 4'd8 && fin) begin
        digest_valid <= 1'b1;
        fin          <= 1'b0;
        count        <= 61'd0;
        pad_active   <= 1'b0;
        sent80       <= 1'b0;
        len_ok       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      case (pos[1:0])
        2'd0: acc[23:16] <= place_byte;
        2'd1: acc[15:8]  <= place_byte;
        2'd2: acc[7:0]   <= place_byte;
        default: begin
        end
      endcase
    end
    if (state == sha_pkg::S_UPD && !upd_stall && cnt != 4'd0 && fin) begin
      digest <= {digest[223:0], sum};
    end
  end

  assign digest_high      = digest[255:192];
  assign digest_upper_mid = digest[191:128];
  assign digest_lower_mid = digest[127:64];
  assign digest_low       = digest[63:0];

  `SHA_ASSERT_NR(a_reset_state, clk, rst |=> (state == sha_pkg::S_INIT && !digest_valid))
  `SHA_ASSERT(a_digest_from_update, clk, rst, $rose(digest_valid) |-> ($past(state) == sha_pkg::S_UPD))
  `SHA_ASSERT(a_message_cleared, clk, rst, $rose(digest_valid) |-> (count == 61'd0 && !pad_active && pos == 6'd0))
  `SHA_ASSERT(a_round_advance, clk, rst, (state == sha_pkg::S_ROUND && rnd != 6'd63) |=> (state == sha_pkg::S_ROUND && rnd == $past(rnd) + 6'd1))
  `SHA_ASSERT(a_chain_no_overlap, clk, rst, (state == sha_pkg::S_UPD && cw_en && cnt != 4'd8) |-> (cw_addr != cr_addr))

endmodule

/* tb/tb.sv */
// Self-checking testbench for sha256_stream_hash_top: streams byte messages and
// compares every digest against an in-bench SHA-256 model held in a scoreboard.
// Depends only on the RTL of sha256_stream_hash_top and its package.
module tb;

  localparam int ITEM_TARGET = 1700;
  localparam int QUIET_ITEMS = 200;

  class sha_scoreboard;
    logic [31:0] round_const [64];
    logic [31:0] start_hash [8];
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [60:0] byte_count;
    logic [255:0] digest_q [$];
    int errors;

    function new();
      round_const = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      start_hash = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
      };
      errors = 0;
      restart_message();
    endfunction

    function void restart_message();
      chain = start_hash;
      for (int i = 0; i < 16; i++) blk[i] = 32'h0;
      byte_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      w = blk;
      v = chain;
      for (int r = 0; r < 64; r++) begin
        if (r >= 16) begin
          s0 = rotr(w[(r - 15) % 16], 7) ^ rotr(w[(r - 15) % 16], 18) ^ (w[(r - 15) % 16] >> 3);
          s1 = rotr(w[(r - 2) % 16], 17) ^ rotr(w[(r - 2) % 16], 19) ^ (w[(r - 2) % 16] >> 10);
          w[r % 16] = s1 + w[(r - 7) % 16] + s0 + w[r % 16];
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[r] + w[r % 16];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    // Big-endian packing; the 64th byte of a block triggers a compression.
    function void place_byte(logic [5:0] pos, logic [7:0] data);
      logic [31:0] lane;
      lane = {24'h0, data} << ((3 - pos[1:0]) * 8);
      if (pos[1:0] == 2'd0) blk[pos[5:2]] = lane;
      else blk[pos[5:2]] = blk[pos[5:2]] | lane;
      if (pos == 6'd63) compress_block();
    endfunction

    function void note_beat(logic [7:0] data, logic present, logic last);
      logic [5:0] pos;
      logic [63:0] bit_len;
      logic [255:0] hash_out;
      if (present) begin
        place_byte(byte_count[5:0], data);
        byte_count = byte_count + 61'd1;
      end
      if (!last) return;
      pos = byte_count[5:0];
      place_byte(pos, 8'h80);
      pos = pos + 6'd1;
      while (pos != 6'd56) begin
        place_byte(pos, 8'h00);
        pos = pos + 6'd1;
      end
      bit_len = {byte_count, 3'b000};
      for (int i = 7; i >= 0; i--) begin
        place_byte(pos, bit_len[i * 8 +: 8]);
        pos = pos + 6'd1;
      end
      hash_out = {chain[0], chain[1], chain[2], chain[3],
                  chain[4], chain[5], chain[6], chain[7]};
      digest_q.insert(digest_q.size(), hash_out);
      restart_message();
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_digest(logic [63:0] d_high, logic [63:0] d_umid,
                      logic [63:0] d_lmid, logic [63:0] d_low);
      logic [255:0] want;
      if (digest_q.size() == 0) begin
        report_mismatch("digest beat with no message outstanding", d_high, 64'h0);
        return;
      end
      want = digest_q.pop_front();
      if (d_high !== want[255:192]) report_mismatch("digest_high", d_high, want[255:192]);
      if (d_umid !== want[191:128]) report_mismatch("digest_upper_mid", d_umid, want[191:128]);
      if (d_lmid !== want[127:64]) report_mismatch("digest_lower_mid", d_lmid, want[127:64]);
      if (d_low !== want[63:0]) report_mismatch("digest_low", d_low, want[63:0]);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        msg_valid;
  logic        msg_ready;
  logic [7:0]  message_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        digest_valid;
  logic        digest_ready;
  logic [63:0] digest_high;
  logic [63:0] digest_upper_mid;
  logic [63:0] digest_lower_mid;
  logic [63:0] digest_low;

  sha_scoreboard sb;
  int  items_sent;
  bit  quiet;

  sha256_stream_hash_top dut (
    .clk              (clk),
    .rst              (rst),
    .msg_valid        (msg_valid),
    .msg_ready        (msg_ready),
    .message_byte     (message_byte),
    .byte_present     (byte_present),
    .end_of_message   (end_of_message),
    .digest_valid     (digest_valid),
    .digest_ready     (digest_ready),
    .digest_high      (digest_high),
    .digest_upper_mid (digest_upper_mid),
    .digest_lower_mid (digest_lower_mid),
    .digest_low       (digest_low)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 3000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Presents one beat at a falling edge, holds it until accepted, then maybe idles.
  task send_beat(logic [7:0] data, logic present, logic last);
    int gap;
    @(negedge clk);
    msg_valid = 1'b1;
    message_byte = data;
    byte_present = present;
    end_of_message = last;
    do @(posedge clk); while (!msg_ready);
    sb.note_beat(data, present, last);
    if (present || last) items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      msg_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task wait_drained();
    @(negedge clk);
    msg_valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task send_message(int len, int fill);
    logic [7:0] data;
    bit tail_end;
    tail_end = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      case (fill)
        0: data = 8'h00;
        1: data = 8'hff;
        default: data = 8'($urandom_range(0, 255));
      endcase
      send_beat(data, 1'b1, tail_end && (i == len - 1));
    end
    if (!tail_end) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Receiver side: digest_ready drops for random bursts except near the end.
  initial begin
    int hold;
    hold = 0;
    digest_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0 && !quiet) begin
        digest_ready = 1'b0;
        hold--;
      end else begin
        digest_ready = 1'b1;
        hold = 0;
        if (!quiet && $urandom_range(0, 3) == 0) hold = $urandom_range(1, 13);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && digest_valid && digest_ready)
        sb.check_digest(digest_high, digest_upper_mid, digest_lower_mid, digest_low);
    end
  end

  initial begin
    int len;
    int kind;
    int fill;
    sb = new();
    items_sent = 0;
    quiet = 1'b0;
    rst = 1'b1;
    msg_valid = 1'b0;
    message_byte = 8'h00;
    byte_present = 1'b0;
    end_of_message = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed: empty message, ignored beats, one-byte messages, "abc", a two-byte message.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'haa, 1'b1, 1'b0);
    send_beat(8'h55, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      quiet = (items_sent > ITEM_TARGET - QUIET_ITEMS);
      kind = $urandom_range(0, 9);
      if (kind < 4) len = $urandom_range(0, 20);
      else if (kind < 6) begin
        // Lengths around the one-block and two-block padding boundaries.
        case ($urandom_range(0, 9))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          7: len = 120;
          8: len = 127;
          default: len = 128;
        endcase
      end else if (kind < 9) len = $urandom_range(21, 130);
      else len = $urandom_range(131, 200);
      fill = $urandom_range(0, 7);
      send_message(len, fill);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    @(negedge clk);
    msg_valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
